[rtl/pftp_pkg.sv]
package pftp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 8;
   localparam int UNIT_BITS   = 30;
   localparam int COEF_WIDTH  = 36;
   localparam int OFFS_WIDTH  = 54;
   localparam int NORM_WIDTH  = 20;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int CROSS_WIDTH = 2 * DIFF_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * CROSS_WIDTH + 2;
   localparam int ROOT_WIDTH  = SQ_WIDTH / 2;
   localparam int QUO_WIDTH   = 40;
   localparam int NUM_WIDTH   = CROSS_WIDTH + UNIT_BITS + 1;
   localparam int PROD_WIDTH  = QUO_WIDTH + COORD_WIDTH + 1;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int MIN_NORM_RESET = 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   // Payload carried from one cell to the next.
   typedef struct packed {
      logic                    valid;
      logic                    normalize;
      coord_type               x0;
      coord_type               y0;
      coord_type               z0;
      cross_type               a;
      cross_type               b;
      cross_type               c;
      logic [SQ_WIDTH-1:0]     sq_rem;
      logic [ROOT_WIDTH-1:0]   root;
   } root_slot_type;

   typedef struct packed {
      logic                    valid;
      logic                    normalize;
      logic                    degenerate;
      coord_type               x0;
      coord_type               y0;
      coord_type               z0;
      cross_type               a;
      cross_type               b;
      cross_type               c;
      logic [ROOT_WIDTH-1:0]   norm;
      logic [NUM_WIDTH-1:0]    rem_a;
      logic [NUM_WIDTH-1:0]    rem_b;
      logic [NUM_WIDTH-1:0]    rem_c;
      logic [QUO_WIDTH-1:0]    q_a;
      logic [QUO_WIDTH-1:0]    q_b;
      logic [QUO_WIDTH-1:0]    q_c;
   } div_slot_type;

endpackage

[rtl/pftp_root_cell.sv]
// One bit of the restoring square root (non-performing form).
module pftp_root_cell
   import pftp_pkg::*;
#(
   parameter int BIT_POS = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  root_slot_type slot_in,
   output root_slot_type slot_out
);

   root_slot_type slot_ff, slot_in_r;
   logic [SQ_WIDTH-1:0] trial;
   logic [SQ_WIDTH-1:0] root_ext;

   always_comb begin
      // partial root r holds the bits above BIT_POS; trial = (2R + 2^b) * 2^b
      root_ext  = SQ_WIDTH'(slot_in.root);
      trial     = (root_ext << (2 * BIT_POS + 2)) | (SQ_WIDTH'(1) << (2 * BIT_POS));
      slot_in_r = slot_in;
      slot_in_r.root = slot_in.root << 1;
      if (slot_in.sq_rem >= trial) begin
         slot_in_r.sq_rem = slot_in.sq_rem - trial;
         slot_in_r.root   = (slot_in.root << 1) | ROOT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_in_r;
      end
   end

   assign slot_out = slot_ff;

endmodule

[rtl/pftp_div_cell.sv]
// One quotient bit for each of the three component divisions.
module pftp_div_cell
   import pftp_pkg::*;
#(
   parameter int BIT_POS = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  div_slot_type slot_in,
   output div_slot_type slot_out
);

   div_slot_type slot_ff, slot_nx;
   logic [NUM_WIDTH+QUO_WIDTH-1:0] dshift;

   always_comb begin
      dshift  = (NUM_WIDTH + QUO_WIDTH)'(slot_in.norm) << BIT_POS;
      slot_nx = slot_in;
      if ((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_a) >= dshift) begin
         slot_nx.rem_a = NUM_WIDTH'((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_a) - dshift);
         slot_nx.q_a   = slot_in.q_a | (QUO_WIDTH'(1) << BIT_POS);
      end
      if ((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_b) >= dshift) begin
         slot_nx.rem_b = NUM_WIDTH'((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_b) - dshift);
         slot_nx.q_b   = slot_in.q_b | (QUO_WIDTH'(1) << BIT_POS);
      end
      if ((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_c) >= dshift) begin
         slot_nx.rem_c = NUM_WIDTH'((NUM_WIDTH + QUO_WIDTH)'(slot_in.rem_c) - dshift);
         slot_nx.q_c   = slot_in.q_c | (QUO_WIDTH'(1) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_nx;
      end
   end

   assign slot_out = slot_ff;

endmodule

[rtl/plane_from_three_points.sv]
// Plane through three points, fully pipelined.
//
// Input channel req_*: nine signed Q8.8 coordinates and a normalize flag,
// accepted on req_valid && req_ready. Result channel rsp_*: coefficients
// a, b, c, d and a degenerate flag, taken on rsp_valid && rsp_ready.
// csr_we/csr_wdata writes min_norm (reset value 1). Write it only while the block
// is idle; the block itself does not enforce this.
// Throughput: one transaction per clock while the receiver does not stall.
// The pipeline holds three front stages (differences, cross product, sum
// of squares), a chain of root cells (one root bit each), a chain of
// divider cells (one quotient bit each, three lanes), then a product stage
// and the output register, which also takes the offset sum.
//
// All stages advance together whenever the output register is empty or
// being drained; a stalled receiver freezes the whole chain, so nothing is
// lost and req_ready drops. Reset clears every valid bit and sets min_norm
// back to 1.
// Degenerate triples (norm zero or below min_norm) return zeros with
// degenerate set.
module plane_from_three_points
   import pftp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_x0,
   input  logic signed [COORD_WIDTH-1:0] req_y0,
   input  logic signed [COORD_WIDTH-1:0] req_z0,
   input  logic signed [COORD_WIDTH-1:0] req_x1,
   input  logic signed [COORD_WIDTH-1:0] req_y1,
   input  logic signed [COORD_WIDTH-1:0] req_z1,
   input  logic signed [COORD_WIDTH-1:0] req_x2,
   input  logic signed [COORD_WIDTH-1:0] req_y2,
   input  logic signed [COORD_WIDTH-1:0] req_z2,
   input  logic                         req_normalize,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COEF_WIDTH-1:0] rsp_coef_a,
   output logic signed [COEF_WIDTH-1:0] rsp_coef_b,
   output logic signed [COEF_WIDTH-1:0] rsp_coef_c,
   output logic signed [OFFS_WIDTH-1:0] rsp_coef_d,
   output logic                         rsp_degenerate,
   input  logic                         csr_we,
   input  logic [NORM_WIDTH-1:0]        csr_wdata
);

   logic advance;
   logic [NORM_WIDTH-1:0] min_norm_ff;

   // ---- stage 1: differences
   logic s1_valid_ff, s1_norm_ff;
   coord_type s1_x0_ff, s1_y0_ff, s1_z0_ff;
   logic signed [DIFF_WIDTH-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;

   // ---- stage 2: cross product
   logic cx_valid_ff, cx_norm_ff;
   coord_type cx_x0_ff, cx_y0_ff, cx_z0_ff;
   cross_type a_ff, b_ff, c_ff;

   // ---- stage 3: sum of squares
   root_slot_type s2_ff, s2_in;
   logic [CROSS_WIDTH-1:0] ma, mb, mc;

   root_slot_type root_chain [ROOT_WIDTH+1];
   div_slot_type  div_chain  [QUO_WIDTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff <= NORM_WIDTH'(MIN_NORM_RESET);
      end else if (csr_we) begin
         min_norm_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s1_norm_ff  <= req_normalize;
         s1_x0_ff    <= req_x0;
         s1_y0_ff    <= req_y0;
         s1_z0_ff    <= req_z0;
         ux_ff <= DIFF_WIDTH'(req_x1) - DIFF_WIDTH'(req_x0);
         uy_ff <= DIFF_WIDTH'(req_y1) - DIFF_WIDTH'(req_y0);
         uz_ff <= DIFF_WIDTH'(req_z1) - DIFF_WIDTH'(req_z0);
         vx_ff <= DIFF_WIDTH'(req_x2) - DIFF_WIDTH'(req_x0);
         vy_ff <= DIFF_WIDTH'(req_y2) - DIFF_WIDTH'(req_y0);
         vz_ff <= DIFF_WIDTH'(req_z2) - DIFF_WIDTH'(req_z0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_valid_ff <= 1'b0;
      end else if (advance) begin
         cx_valid_ff <= s1_valid_ff;
         cx_norm_ff  <= s1_norm_ff;
         cx_x0_ff    <= s1_x0_ff;
         cx_y0_ff    <= s1_y0_ff;
         cx_z0_ff    <= s1_z0_ff;
         a_ff <= CROSS_WIDTH'(uy_ff * vz_ff) - CROSS_WIDTH'(uz_ff * vy_ff);
         b_ff <= CROSS_WIDTH'(uz_ff * vx_ff) - CROSS_WIDTH'(ux_ff * vz_ff);
         c_ff <= CROSS_WIDTH'(ux_ff * vy_ff) - CROSS_WIDTH'(uy_ff * vx_ff);
      end
   end

   always_comb begin
      ma = a_ff[CROSS_WIDTH-1] ? CROSS_WIDTH'(-a_ff) : CROSS_WIDTH'(a_ff);
      mb = b_ff[CROSS_WIDTH-1] ? CROSS_WIDTH'(-b_ff) : CROSS_WIDTH'(b_ff);
      mc = c_ff[CROSS_WIDTH-1] ? CROSS_WIDTH'(-c_ff) : CROSS_WIDTH'(c_ff);
      s2_in.valid     = cx_valid_ff;
      s2_in.normalize = cx_norm_ff;
      s2_in.x0 = cx_x0_ff;
      s2_in.y0 = cx_y0_ff;
      s2_in.z0 = cx_z0_ff;
      s2_in.a  = a_ff;
      s2_in.b  = b_ff;
      s2_in.c  = c_ff;
      s2_in.sq_rem = SQ_WIDTH'(ma * ma) + SQ_WIDTH'(mb * mb) + SQ_WIDTH'(mc * mc);
      s2_in.root   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff <= s2_in;
      end
   end

   // ---- square root chain, MSB first
   assign root_chain[0] = s2_ff;

   for (genvar gi = 0; gi < ROOT_WIDTH; gi++) begin : g_root
      pftp_root_cell #(.BIT_POS(ROOT_WIDTH - 1 - gi)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .slot_in  (root_chain[gi]),
         .slot_out (root_chain[gi+1])
      );
   end

   // ---- degenerate check and divider setup
   root_slot_type rt;
   div_slot_type  dv_in;
   logic [CROSS_WIDTH-1:0] na, nb, nc;
   logic [NUM_WIDTH-1:0]   half;

   always_comb begin
      rt = root_chain[ROOT_WIDTH];
      na = rt.a[CROSS_WIDTH-1] ? CROSS_WIDTH'(-rt.a) : CROSS_WIDTH'(rt.a);
      nb = rt.b[CROSS_WIDTH-1] ? CROSS_WIDTH'(-rt.b) : CROSS_WIDTH'(rt.b);
      nc = rt.c[CROSS_WIDTH-1] ? CROSS_WIDTH'(-rt.c) : CROSS_WIDTH'(rt.c);
      half = NUM_WIDTH'(rt.root >> 1);
      dv_in.valid      = rt.valid;
      dv_in.normalize  = rt.normalize;
      dv_in.degenerate = (rt.root == '0) ||
                         (ROOT_WIDTH'(rt.root) < ROOT_WIDTH'(min_norm_ff));
      dv_in.x0 = rt.x0;
      dv_in.y0 = rt.y0;
      dv_in.z0 = rt.z0;
      dv_in.a  = rt.a;
      dv_in.b  = rt.b;
      dv_in.c  = rt.c;
      // a zero divisor only occurs for degenerate items; force one to keep it tame
      dv_in.norm  = (rt.root == '0) ? ROOT_WIDTH'(1) : rt.root;
      dv_in.rem_a = (NUM_WIDTH'(na) << UNIT_BITS) + half;
      dv_in.rem_b = (NUM_WIDTH'(nb) << UNIT_BITS) + half;
      dv_in.rem_c = (NUM_WIDTH'(nc) << UNIT_BITS) + half;
      dv_in.q_a = '0;
      dv_in.q_b = '0;
      dv_in.q_c = '0;
   end

   assign div_chain[0] = dv_in;

   for (genvar gj = 0; gj < QUO_WIDTH; gj++) begin : g_div
      pftp_div_cell #(.BIT_POS(QUO_WIDTH - 1 - gj)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .slot_in  (div_chain[gj]),
         .slot_out (div_chain[gj+1])
      );
   end

   // ---- final components and products
   div_slot_type dq;
   logic signed [QUO_WIDTH:0] an, bn, cn;
   logic signed [COEF_WIDTH-1:0] fa_in, fb_in, fc_in;

   always_comb begin
      dq = div_chain[QUO_WIDTH];
      an = dq.a[CROSS_WIDTH-1] ? -$signed({1'b0, dq.q_a}) : $signed({1'b0, dq.q_a});
      bn = dq.b[CROSS_WIDTH-1] ? -$signed({1'b0, dq.q_b}) : $signed({1'b0, dq.q_b});
      cn = dq.c[CROSS_WIDTH-1] ? -$signed({1'b0, dq.q_c}) : $signed({1'b0, dq.q_c});
      if (dq.normalize) begin
         fa_in = COEF_WIDTH'(an);
         fb_in = COEF_WIDTH'(bn);
         fc_in = COEF_WIDTH'(cn);
      end else begin
         fa_in = COEF_WIDTH'(dq.a);
         fb_in = COEF_WIDTH'(dq.b);
         fc_in = COEF_WIDTH'(dq.c);
      end
   end

   logic p_valid_ff, p_norm_ff, p_deg_ff;
   logic signed [COEF_WIDTH-1:0] p_a_ff, p_b_ff, p_c_ff;
   logic signed [PROD_WIDTH-1:0] pa_ff, pb_ff, pc_ff;

   // full products against x0, y0, z0 (normalized quotient or raw component)
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= dq.valid;
         p_norm_ff  <= dq.normalize;
         p_deg_ff   <= dq.degenerate;
         p_a_ff     <= fa_in;
         p_b_ff     <= fb_in;
         p_c_ff     <= fc_in;
         pa_ff <= PROD_WIDTH'((dq.normalize ? an : (QUO_WIDTH+1)'(dq.a)) * dq.x0);
         pb_ff <= PROD_WIDTH'((dq.normalize ? bn : (QUO_WIDTH+1)'(dq.b)) * dq.y0);
         pc_ff <= PROD_WIDTH'((dq.normalize ? cn : (QUO_WIDTH+1)'(dq.c)) * dq.z0);
      end
   end

   logic signed [SUM_WIDTH-1:0] s_sum, s_neg;
   logic signed [OFFS_WIDTH-1:0] d_in;

   always_comb begin
      s_sum = SUM_WIDTH'(pa_ff) + SUM_WIDTH'(pb_ff) + SUM_WIDTH'(pc_ff);
      if (p_norm_ff) begin
         s_neg = SUM_WIDTH'((1 << FRAC_BITS) >> 1) - s_sum;
         d_in  = OFFS_WIDTH'(s_neg >>> FRAC_BITS);
      end else begin
         s_neg = -s_sum;
         d_in  = OFFS_WIDTH'(s_neg);
      end
   end

   // ---- output register
   logic out_valid_ff, out_deg_ff;
   logic signed [COEF_WIDTH-1:0] out_a_ff, out_b_ff, out_c_ff;
   logic signed [OFFS_WIDTH-1:0] out_d_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= p_valid_ff;
         out_deg_ff   <= p_deg_ff;
         out_a_ff     <= p_deg_ff ? '0 : p_a_ff;
         out_b_ff     <= p_deg_ff ? '0 : p_b_ff;
         out_c_ff     <= p_deg_ff ? '0 : p_c_ff;
         out_d_ff     <= p_deg_ff ? '0 : d_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_coef_a     = out_a_ff;
   assign rsp_coef_b     = out_b_ff;
   assign rsp_coef_c     = out_c_ff;
   assign rsp_coef_d     = out_d_ff;
   assign rsp_degenerate = out_deg_ff;

endmodule

[rtl/pftp_checker.sv]
module pftp_checker
   import pftp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COEF_WIDTH-1:0] rsp_coef_a,
   input logic [COEF_WIDTH-1:0] rsp_coef_b,
   input logic [COEF_WIDTH-1:0] rsp_coef_c,
   input logic [OFFS_WIDTH-1:0] rsp_coef_d,
   input logic                  rsp_degenerate
);

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_coef_a == '0 && rsp_coef_b == '0 && rsp_coef_c == '0 && rsp_coef_d == '0)
      else $error("degenerate result with nonzero coefficients");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coef_d))
      else $error("result changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

bind plane_from_three_points pftp_checker u_pftp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_coef_a     (rsp_coef_a),
   .rsp_coef_b     (rsp_coef_b),
   .rsp_coef_c     (rsp_coef_c),
   .rsp_coef_d     (rsp_coef_d),
   .rsp_degenerate (rsp_degenerate)
);
